### rtl/blr_pkg.sv
package blr_pkg;

    localparam int DIM_W   = 11;
    localparam int COLOR_W = 32;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd480;
    localparam logic [COLOR_W-1:0] COLOR_RST  = 32'd0;

    // step flag bit positions
    localparam int FLAG_XNEG  = 0;
    localparam int FLAG_YNEG  = 1;
    localparam int FLAG_XMAJ  = 2;
    localparam int FLAG_W     = 3;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COLOR  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COLOR_W-1:0] color;
    } t_cfg;

endpackage

### rtl/blr_cfg_regs.sv
module blr_cfg_regs
    import blr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  n_cfg.width  = pwdata[DIM_W-1:0];
                REG_HEIGHT: n_cfg.height = pwdata[DIM_W-1:0];
                REG_COLOR:  n_cfg.color  = pwdata[COLOR_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_cfg.color  <= COLOR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DW'(r_cfg.width);
            REG_HEIGHT: prdata = APB_DW'(r_cfg.height);
            REG_COLOR:  prdata = APB_DW'(r_cfg.color);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/blr_walker.sv
module blr_walker
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  t_cfg                         i_cfg,
    output logic                         o_emit,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_in_image,
    output logic                         o_last
);

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 3;
    localparam int DW  = C + 1;
    localparam int CMW = (C > DIM_W) ? C : DIM_W;

    logic signed [C-1:0]  r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic signed [EW-1:0] r_err;
    logic [DW-1:0]        r_dec, r_inc;
    logic [FLAG_W-1:0]    r_flags;
    logic                 r_active;

    logic signed [C-1:0]  n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic signed [EW-1:0] n_err;
    logic [DW-1:0]        n_dec, n_inc;
    logic [FLAG_W-1:0]    n_flags;
    logic                 n_active;

    // load setup
    logic signed [C:0] ddx, ddy;
    logic [C:0]        abs_x_w, abs_y_w;
    logic [C-1:0]      ax, ay, major, minor;
    logic              xmajor;
    logic [DW-1:0]     dbl_major, dbl_minor;
    logic signed [EW-1:0] err_init;

    // step
    logic [C-1:0]         inc_x, inc_y;
    logic signed [C-1:0]  adv_x, adv_y;
    logic signed [C-1:0]  step_x, step_y;
    logic signed [EW-1:0] err_step;
    logic                 diag;
    logic                 last;
    logic                 in_bounds;

    assign ddx = (C+1)'(i_end_x) - (C+1)'(i_start_x);
    assign ddy = (C+1)'(i_end_y) - (C+1)'(i_start_y);
    assign abs_x_w = ddx[C] ? -ddx : ddx;
    assign abs_y_w = ddy[C] ? -ddy : ddy;
    assign ax = abs_x_w[C-1:0];
    assign ay = abs_y_w[C-1:0];
    // ties go to y as the major axis
    assign xmajor = ax > ay;
    assign major  = xmajor ? ax : ay;
    assign minor  = xmajor ? ay : ax;
    assign dbl_major = {major, 1'b0};
    assign dbl_minor = {minor, 1'b0};
    assign err_init  = $signed(EW'(dbl_minor)) - $signed(EW'(major));

    assign inc_x = r_flags[FLAG_XNEG] ? '1 : C'(1);
    assign inc_y = r_flags[FLAG_YNEG] ? '1 : C'(1);
    assign adv_x = r_cur_x + $signed(inc_x);
    assign adv_y = r_cur_y + $signed(inc_y);
    assign diag  = r_err > 0;

    always_comb begin
        step_x = r_cur_x;
        step_y = r_cur_y;
        if (diag) begin
            step_x = adv_x;
            step_y = adv_y;
        end else if (r_flags[FLAG_XMAJ]) begin
            step_x = adv_x;
        end else begin
            step_y = adv_y;
        end
    end

    assign err_step = r_err - (diag ? $signed(EW'(r_dec)) : EW'(0)) + $signed(EW'(r_inc));
    assign last = (step_x == r_goal_x) && (step_y == r_goal_y);

    assign in_bounds = !r_cur_x[C-1] && !r_cur_y[C-1] &&
                       (CMW'($unsigned(r_cur_x)) < CMW'(i_cfg.width)) &&
                       (CMW'($unsigned(r_cur_y)) < CMW'(i_cfg.height));

    assign o_emit     = i_step && r_active;
    assign o_pixel_x  = r_cur_x;
    assign o_pixel_y  = r_cur_y;
    assign o_in_image = in_bounds;
    assign o_last     = last;

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_goal_x = r_goal_x;
        n_goal_y = r_goal_y;
        n_err    = r_err;
        n_dec    = r_dec;
        n_inc    = r_inc;
        n_flags  = r_flags;
        n_active = r_active;
        if (i_load) begin
            n_cur_x  = i_start_x;
            n_cur_y  = i_start_y;
            n_goal_x = i_end_x;
            n_goal_y = i_end_y;
            n_err    = err_init;
            n_dec    = dbl_major;
            n_inc    = dbl_minor;
            n_flags[FLAG_XNEG] = ddx[C];
            n_flags[FLAG_YNEG] = ddy[C];
            n_flags[FLAG_XMAJ] = xmajor;
            n_active = (i_start_x != i_end_x) || (i_start_y != i_end_y);
        end else if (o_emit) begin
            n_cur_x  = step_x;
            n_cur_y  = step_y;
            n_err    = err_step;
            n_active = !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_err    <= '0;
            r_dec    <= '0;
            r_inc    <= '0;
            r_flags  <= '0;
            r_active <= 1'b0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_goal_x <= n_goal_x;
            r_goal_y <= n_goal_y;
            r_err    <= n_err;
            r_dec    <= n_dec;
            r_inc    <= n_inc;
            r_flags  <= n_flags;
            r_active <= n_active;
        end
    end

endmodule

### rtl/bresenham_line_rasterizer.sv
// Bresenham line walker for all octants. A load transaction (req_type 0) takes the start and
// end points and returns nothing; each step transaction (req_type 1) returns the current pixel
// with its in-image flag and the draw color, then moves one pixel toward the end point. The
// start point is drawn, the end point is not, and last_pixel marks the final pixel of a line.
// Steps on an idle line and zero-length lines return nothing; a load replaces any active line.
// The walker state updates at the accepting edge and the pixel lands in an output register,
// so a new transaction is taken each cycle as long as the output register is empty or being
// drained, and an accepted step's pixel shows at the outputs in the next cycle. Image size and
// color sit behind an APB port; write them only while idle (the block does not enforce this).
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_AW-1:0]            paddr,
    input  logic [APB_DW-1:0]            pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_in_image,
    output logic [COLOR_W-1:0]           o_pixel_color,
    output logic                         o_last_pixel
);

    t_cfg cfg;
    logic in_acc;
    logic emit;
    logic signed [COORD_BITS-1:0] w_pixel_x, w_pixel_y;
    logic w_in_image, w_last;

    logic                         r_out_valid, n_out_valid;
    logic signed [COORD_BITS-1:0] r_pixel_x, r_pixel_y;
    logic                         r_in_image, r_last;
    logic [COLOR_W-1:0]           r_color;

    blr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    blr_walker #(.COORD_BITS(COORD_BITS)) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_acc && (i_req_type == REQ_LOAD)),
        .i_step     (in_acc && (i_req_type == REQ_STEP)),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_cfg      (cfg),
        .o_emit     (emit),
        .o_pixel_x  (w_pixel_x),
        .o_pixel_y  (w_pixel_y),
        .o_in_image (w_in_image),
        .o_last     (w_last)
    );

    // output slot refills on an accepted step and empties on a load; otherwise holds while stalled
    assign n_out_valid = in_acc ? emit : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel_x  <= w_pixel_x;
            r_pixel_y  <= w_pixel_y;
            r_in_image <= w_in_image;
            r_last     <= w_last;
            r_color    <= cfg.color;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_in_image    = r_in_image;
    assign o_pixel_color = r_color;
    assign o_last_pixel  = r_last;

endmodule

### rtl/blr_checker.sv
module blr_checker
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_req_type,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [COORD_BITS-1:0] o_pixel_x,
    input logic signed [COORD_BITS-1:0] o_pixel_y,
    input logic                         o_last_pixel
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // input side only backs up when a result is waiting and stalled
    a_stall_cause: assert property (@(posedge i_clk)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // a load transaction never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req_type == REQ_LOAD)) |=> !o_out_valid)
        else $error("result appeared after a load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last_pixel)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_req_type   (i_req_type),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last_pixel (o_last_pixel)
);
